// File: src/assert_macros.svh
// Assertion helpers shared by the parser files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gtpcp_pkg.sv
package gtpcp_pkg;

  localparam int unsigned MaxElementsDef = 32;
  localparam logic [16:0] PosMax = 17'h1FFFF;

  typedef enum logic [1:0] {
    KIND_IE     = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    RSN_NONE      = 4'd0,
    RSN_SHORT     = 4'd1,
    RSN_VER_PT    = 4'd2,
    RSN_SHORT_OPT = 4'd3,
    RSN_EXT_ZERO  = 4'd4,
    RSN_EXT_OVER  = 4'd5,
    RSN_TRUNC     = 4'd6,
    RSN_UNK_TV    = 4'd7,
    RSN_EL_OVER   = 4'd8
  } reason_t;

  typedef enum logic [1:0] {
    EXT_NONE = 2'd0,
    EXT_LEN  = 2'd1,
    EXT_BODY = 2'd2
  } ext_t;

  typedef enum logic [2:0] {
    EL_TYPE   = 3'd0,
    EL_LEN_HI = 3'd1,
    EL_LEN_LO = 3'd2,
    EL_VALUE  = 3'd3,
    EL_HALT   = 3'd4
  } el_t;

  // One result row as seen by the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ie_type;
    logic [15:0] ie_length;
    logic [16:0] value_offset;
    logic [7:0]  message_type;
    logic [31:0] tunnel_id;
    logic [15:0] sequence_number;
    logic [5:0]  element_count;
    reason_t     reject_reason;
    logic        final_flag;
  } row_t;

  // TV value length; 0 for types not in the table.
  function automatic logic [4:0] tv_size(input logic [7:0] t);
    logic [4:0] s;
    unique case (t)
      8'd1, 8'd8, 8'd11, 8'd13, 8'd14, 8'd15, 8'd19, 8'd20,
      8'd21, 8'd23, 8'd24, 8'd29: s = 5'd1;
      8'd25, 8'd26, 8'd27, 8'd28: s = 5'd2;
      8'd12: s = 5'd3;
      8'd4, 8'd5, 8'd16, 8'd17, 8'd127: s = 5'd4;
      8'd18: s = 5'd5;
      8'd3: s = 5'd6;
      8'd2: s = 5'd8;
      8'd22: s = 5'd9;
      8'd9: s = 5'd28;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// File: src/gtpcp_out_queue.sv
// Two-entry result queue: holds up to two rows produced by one byte.
module gtpcp_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  gtpcp_pkg::row_t   row0,
  input  logic              push1,
  input  gtpcp_pkg::row_t   row1,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output gtpcp_pkg::row_t   out_row
);
  import gtpcp_pkg::*;
  `include "assert_macros.svh"

  row_t       slot_r [2];
  row_t       slot_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] npush;
  logic [1:0] base;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_row   = slot_r[0];
  // Take a new item only when two rows always fit after this cycle's pop.
  assign can_take  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign npush     = {1'b0, push0} + {1'b0, push1};
  assign base      = cnt_r - {1'b0, pop};
  assign cnt_nxt   = base + npush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (pop) slot_nxt[0] = slot_r[1];
    if (push0) begin
      slot_nxt[base[0]] = row0;
      if (push1) slot_nxt[1] = row1;
    end else if (push1) begin
      slot_nxt[base[0]] = row1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, push0 || push1, base == 2'd0, "push into busy queue")
  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `ASSERT_IMPL(a_push_order, clk, rst_n, push1 && !push0, row1.final_flag, "lone second row not final")
endmodule

// File: src/gtp_control_message_parser.sv
// Channel | ports                                   | accepted when
// in      | in_data_byte, in_last_byte              | in_valid && in_ready
// out     | out_kind .. out_final_flag (10 fields)  | out_valid && out_ready
// One byte per cycle if in_ready; its first row appears the cycle after it is taken.
// A byte yields at most two rows (descriptor + final); a two-row queue holds them.
// in_ready is high only while the queue is empty or its single row leaves this cycle.
// Synchronous active-low reset clears all parse state and the queue.
module gtp_control_message_parser #(
  parameter int unsigned MAX_ELEMENTS = gtpcp_pkg::MaxElementsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gtpcp_pkg::kind_t     out_kind,
  output logic [7:0]           out_ie_type,
  output logic [15:0]          out_ie_length,
  output logic [16:0]          out_value_offset,
  output logic [7:0]           out_message_type,
  output logic [31:0]          out_tunnel_id,
  output logic [15:0]          out_sequence_number,
  output logic [5:0]           out_element_count,
  output gtpcp_pkg::reason_t   out_reject_reason,
  output logic                 out_final_flag
);
  import gtpcp_pkg::*;
  `include "assert_macros.svh"

  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  flags_r, flags_nxt, mtype_r, mtype_nxt, etype_r, etype_nxt;
  logic [15:0] plen_r, plen_nxt, seq_r, seq_nxt, eleft_r, eleft_nxt, elen_r, elen_nxt;
  logic [31:0] teid_r, teid_nxt;
  ext_t        ext_r, ext_nxt;
  logic [9:0]  xleft_r, xleft_nxt;
  el_t         el_r, el_nxt;
  logic [5:0]  found_r, found_nxt;
  reason_t     pend_r, pend_nxt;

  logic        acc, b_last, opt, walk;
  logic [7:0]  b;
  logic [17:0] p1, end_pos, need;
  logic [16:0] hdr_end;
  logic        push0, push1, can_take;
  row_t        row0, row1, q_row;
  reason_t     rsn;
  logic [4:0]  tvl;

  assign in_ready = can_take;
  assign acc      = in_valid && in_ready;
  assign b        = in_data_byte;
  assign b_last   = in_last_byte;
  assign p1       = {1'b0, pos_r} + 18'd1;
  assign tvl      = tv_size(b);

  always_comb begin
    flags_nxt = flags_r; mtype_nxt = mtype_r; plen_nxt = plen_r; teid_nxt = teid_r;
    seq_nxt = seq_r; ext_nxt = ext_r; xleft_nxt = xleft_r; el_nxt = el_r;
    etype_nxt = etype_r; eleft_nxt = eleft_r; elen_nxt = elen_r;
    found_nxt = found_r; pend_nxt = pend_r;
    push0 = 1'b0; push1 = 1'b0; walk = 1'b0; need = '0; rsn = RSN_NONE;
    opt = (flags_r[2:0] != 3'd0);
    pos_nxt = (pos_r != PosMax) ? p1[16:0] : pos_r;

    if (pos_r == 17'd0) begin
      flags_nxt = b;
      opt = (b[2:0] != 3'd0);
      if (b[7:5] != 3'd1 || !b[4]) pend_nxt = RSN_VER_PT;
    end else if (pos_r == 17'd1) begin
      mtype_nxt = b;
    end else if (pos_r == 17'd2 || pos_r == 17'd3) begin
      plen_nxt = {plen_r[7:0], b};
    end else if (pos_r >= 17'd4 && pos_r <= 17'd7) begin
      teid_nxt = {teid_r[23:0], b};
    end else if (opt && (pos_r == 17'd8 || pos_r == 17'd9)) begin
      seq_nxt = {seq_r[7:0], b};
    end

    hdr_end = opt ? 17'd12 : 17'd8;
    end_pos = 18'd8 + {2'b0, plen_nxt};

    if (pend_r == RSN_NONE && pend_nxt == RSN_NONE) begin
      if (opt && pos_r == 17'd11) begin
        if (flags_r[2] && b != 8'd0) ext_nxt = EXT_LEN;
      end else if (pos_r >= hdr_end) begin
        priority case (ext_r)
          EXT_LEN: begin
            if (b_last) begin
              ext_nxt = EXT_NONE;
              walk = 1'b1;
            end else if (b == 8'd0) begin
              pend_nxt = RSN_EXT_ZERO;
            end else begin
              xleft_nxt = {b, 2'b00} - 10'd1;
              ext_nxt = EXT_BODY;
            end
          end
          EXT_BODY: begin
            if (xleft_r <= 10'd1) begin
              xleft_nxt = '0;
              ext_nxt = (b == 8'd0) ? EXT_NONE : EXT_LEN;
            end else if (b_last) begin
              pend_nxt = RSN_EXT_OVER;
            end else begin
              xleft_nxt = xleft_r - 10'd1;
            end
          end
          default: walk = 1'b1;
        endcase
      end
    end

    if (walk && el_r != EL_HALT && {1'b0, pos_r} < end_pos) begin
      if ({26'b0, found_r} >= MAX_ELEMENTS) begin
        el_nxt = EL_HALT;
      end else begin
        unique case (el_r)
          EL_TYPE: begin
            etype_nxt = b;
            if (!b[7]) begin
              need = p1 + {13'b0, tvl};
              if (tvl == 5'd0) begin
                pend_nxt = RSN_UNK_TV; el_nxt = EL_HALT;
              end else if (need > end_pos) begin
                pend_nxt = RSN_EL_OVER; el_nxt = EL_HALT;
              end else begin
                elen_nxt = {11'b0, tvl}; eleft_nxt = {11'b0, tvl}; el_nxt = EL_VALUE;
              end
            end else if (p1 + 18'd2 > end_pos) begin
              pend_nxt = RSN_EL_OVER; el_nxt = EL_HALT;
            end else begin
              el_nxt = EL_LEN_HI;
            end
          end
          EL_LEN_HI: begin
            eleft_nxt = {b, 8'd0};
            el_nxt = EL_LEN_LO;
          end
          EL_LEN_LO: begin
            need = p1 + {2'b0, eleft_r[15:8], b};
            if (need > end_pos) begin
              pend_nxt = RSN_EL_OVER; el_nxt = EL_HALT;
            end else begin
              elen_nxt = {eleft_r[15:8], b}; eleft_nxt = {eleft_r[15:8], b};
              if ({eleft_r[15:8], b} == 16'd0) begin
                found_nxt = found_r + 6'd1; el_nxt = EL_TYPE; push0 = 1'b1;
              end else begin
                el_nxt = EL_VALUE;
              end
            end
          end
          EL_VALUE: begin
            eleft_nxt = eleft_r - 16'd1;
            if (eleft_r == 16'd1) begin
              found_nxt = found_r + 6'd1; el_nxt = EL_TYPE; push0 = 1'b1;
            end
          end
          default: el_nxt = EL_HALT;
        endcase
      end
    end

    row0.kind = KIND_IE;
    row0.ie_type = etype_nxt;
    row0.ie_length = elen_nxt;
    row0.value_offset = p1[16:0] - {1'b0, elen_nxt};
    row0.message_type = mtype_nxt;
    row0.tunnel_id = teid_nxt;
    row0.sequence_number = seq_nxt;
    row0.element_count = found_nxt;
    row0.reject_reason = RSN_NONE;
    row0.final_flag = 1'b0;

    if (p1 < 18'd8) rsn = RSN_SHORT;
    else if (pend_nxt == RSN_VER_PT) rsn = RSN_VER_PT;
    else if (opt && p1 < 18'd12) rsn = RSN_SHORT_OPT;
    else if (pend_nxt == RSN_EXT_ZERO || pend_nxt == RSN_EXT_OVER) rsn = pend_nxt;
    else if (end_pos > p1) rsn = RSN_TRUNC;
    else rsn = pend_nxt;

    row1 = row0;
    row1.kind = (rsn != RSN_NONE) ? KIND_REJECT : KIND_ACCEPT;
    row1.ie_type = '0;
    row1.ie_length = '0;
    row1.value_offset = '0;
    row1.reject_reason = rsn;
    row1.final_flag = 1'b1;
    push1 = b_last;

    push0 = push0 && acc;
    push1 = push1 && acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && b_last)) begin
      pos_r <= '0; flags_r <= '0; mtype_r <= '0; plen_r <= '0; teid_r <= '0;
      seq_r <= '0; ext_r <= EXT_NONE; xleft_r <= '0; el_r <= EL_TYPE;
      etype_r <= '0; eleft_r <= '0; elen_r <= '0; found_r <= '0; pend_r <= RSN_NONE;
    end else if (acc) begin
      pos_r <= pos_nxt; flags_r <= flags_nxt; mtype_r <= mtype_nxt; plen_r <= plen_nxt;
      teid_r <= teid_nxt; seq_r <= seq_nxt; ext_r <= ext_nxt; xleft_r <= xleft_nxt;
      el_r <= el_nxt; etype_r <= etype_nxt; eleft_r <= eleft_nxt; elen_r <= elen_nxt;
      found_r <= found_nxt; pend_r <= pend_nxt;
    end
  end

  gtpcp_out_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push0(push0), .row0(row0), .push1(push1), .row1(row1),
    .can_take(can_take), .out_valid(out_valid), .out_ready(out_ready), .out_row(q_row)
  );

  assign out_kind            = q_row.kind;
  assign out_ie_type         = q_row.ie_type;
  assign out_ie_length       = q_row.ie_length;
  assign out_value_offset    = q_row.value_offset;
  assign out_message_type    = q_row.message_type;
  assign out_tunnel_id       = q_row.tunnel_id;
  assign out_sequence_number = q_row.sequence_number;
  assign out_element_count   = q_row.element_count;
  assign out_reject_reason   = q_row.reject_reason;
  assign out_final_flag      = q_row.final_flag;

  `ASSERT_IMPL(a_found_cap, clk, rst_n, 1'b1, {26'b0, found_r} <= MAX_ELEMENTS, "count over cap")
  `ASSERT_NEXT(a_last_clears, clk, rst_n, acc && b_last, pos_r == 17'd0, "no reset after last")
  `ASSERT_IMPL(a_halt_stays, clk, rst_n, el_r == EL_HALT && acc && !b_last, el_nxt == EL_HALT,
    "walk left halt")
endmodule
